FILE: design/paq_pkg.sv
// ----------------------------------------------------------------------------
// paq_pkg
// Shared types and constants of the priority alert queue: operation, status
// and event codes, the stored entry and the control word of one queue cell.
// ----------------------------------------------------------------------------
`default_nettype none

package paq_pkg;

   localparam int FUNC_W   = 3;
   localparam int CODE_W   = 32;
   localparam int PRIO_W   = 8;
   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int NOTIFY_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_POST  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_NEXT  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   localparam logic [NOTIFY_W-1:0] NOTIFY_NONE    = 2'd0;
   localparam logic [NOTIFY_W-1:0] NOTIFY_ADDED   = 2'd1;
   localparam logic [NOTIFY_W-1:0] NOTIFY_CHANGED = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [PRIO_W-1:0]  prio;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SCAN_CLR,
      CELL_SCAN,
      CELL_INSERT,
      CELL_POP
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type       cmd;
      entry_type          item;
      logic [PRIO_W-1:0]  normal;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: design/paq_cell.sv
// ----------------------------------------------------------------------------
// paq_cell
// One slot of the queue. Holds an entry and a flag that says an earlier slot
// is the insert point; the flag ripples one cell per cycle during a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire paq_pkg::cell_ctrl_type ctrl,
   input  wire                         occupied,
   input  wire                         at_tail,
   input  wire paq_pkg::entry_type     left_entry,
   input  wire paq_pkg::entry_type     right_entry,
   input  wire                         left_chain,
   output paq_pkg::entry_type          entry_out,
   output logic                        chain_out
);

   paq_pkg::entry_type entry_ff;
   paq_pkg::entry_type entry_in;
   logic               ahead_ff;
   logic               ahead_in;
   logic               mark;

   // This slot is the insert point if it holds a lower priority (and the new
   // alert is not of normal priority), or if it is the first free slot.
   assign mark = (occupied && (entry_ff.prio < ctrl.item.prio) &&
                  (ctrl.item.prio != ctrl.normal)) || at_tail;

   assign chain_out = ahead_ff | mark;
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      ahead_in = ahead_ff;
      case (ctrl.cmd)
         paq_pkg::CELL_SCAN_CLR: begin
            ahead_in = 1'b0;
         end
         paq_pkg::CELL_SCAN: begin
            ahead_in = left_chain;
         end
         paq_pkg::CELL_INSERT: begin
            if (ahead_ff) begin
               entry_in = left_entry;
            end else if (mark) begin
               entry_in = ctrl.item;
            end
         end
         paq_pkg::CELL_POP: begin
            entry_in = right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead_ff <= 1'b0;
      end else begin
         ahead_ff <= ahead_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: design/priority_alert_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_alert_queue_unit
// Ordered alert queue built as a row of slot cells, with a response register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ stream: req_tuser carries the operation and
//   req_tdata the alert. Each request gives one response on the rsp_ stream.
//   normal_priority is written over the csr_ port while the block is idle.
// Sequencing:
//   A post to a queue that is not full walks the insert-point flag through
//   the cell row, one cell per cycle, in the scan state and then goes to the
//   finish state; every other request goes straight to the finish state. The
//   response is registered in the finish state, and the next request is taken
//   only after the block has returned to idle.
// Reset:
//   Reset empties the queue, clears normal_priority and drops any pending
//   response. Slot contents are not cleared; only occupied slots are read.
// Stall:
//   A request may be accepted while an earlier response still waits; its
//   own response, and every state change it makes, is held back until the
//   response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_alert_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_tvalid,
   output logic        req_tready,
   // [31:0] alert_code, [39:32] alert_priority, [71:40] alert_stamp
   input  wire  [71:0] req_tdata,
   // [2:0] func
   input  wire  [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [1:0] status, [2] entry_valid, [34:3] out_code, [42:35] out_priority,
   // [74:43] out_stamp, [79:75] occupancy, [81:80] notify, [87:82] zero
   output logic [87:0] rsp_tdata,

   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_W = $clog2(QUEUE_DEPTH);
   localparam logic [CW-1:0]    FULL_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] SCAN_LAST  = CNT_W'(QUEUE_DEPTH - 2);
   localparam logic             REG_NORMAL_PRIORITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                        state_ff;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [paq_pkg::FUNC_W-1:0]       op_ff;
   paq_pkg::entry_type               item_ff;
   logic [CW-1:0]                    fill_ff;
   logic [CW-1:0]                    fill_in;
   logic [paq_pkg::PRIO_W-1:0]       normal_ff;

   logic                             rsp_valid_ff;
   logic [paq_pkg::STATUS_W-1:0]     status_ff;
   logic [paq_pkg::STATUS_W-1:0]     status_in;
   logic                             entry_valid_ff;
   logic                             entry_valid_in;
   paq_pkg::entry_type               out_entry_ff;
   paq_pkg::entry_type               out_entry_in;
   logic [paq_pkg::OCC_W-1:0]        occupancy_ff;
   logic [paq_pkg::NOTIFY_W-1:0]     notify_ff;
   logic [paq_pkg::NOTIFY_W-1:0]     notify_in;

   paq_pkg::cell_ctrl_type           ctrl;
   paq_pkg::cell_cmd_type            finish_cmd;
   paq_pkg::entry_type               entry_w [QUEUE_DEPTH];
   logic                             chain_w [QUEUE_DEPTH];
   paq_pkg::entry_type               req_item;

   logic req_accept;
   logic out_free;
   logic full;
   logic csr_write;

   assign req_item.code  = req_tdata[31:0];
   assign req_item.prio  = req_tdata[39:32];
   assign req_item.stamp = req_tdata[71:40];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (fill_ff == FULL_COUNT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      if (csr_paddr[2] == REG_NORMAL_PRIORITY) begin
         csr_prdata = {24'd0, normal_ff};
      end else begin
         csr_prdata = 32'd0;
      end
   end

   // Result of the held request, and the cell action that goes with it.
   always_comb begin
      fill_in        = fill_ff;
      status_in      = paq_pkg::STATUS_OK;
      entry_valid_in = 1'b0;
      out_entry_in   = '0;
      notify_in      = paq_pkg::NOTIFY_NONE;
      finish_cmd     = paq_pkg::CELL_HOLD;
      case (op_ff)
         paq_pkg::FUNC_POST: begin
            if (full) begin
               status_in = paq_pkg::STATUS_FULL;
            end else begin
               finish_cmd = paq_pkg::CELL_INSERT;
               fill_in    = fill_ff + 1'b1;
               if (fill_ff == '0) begin
                  notify_in = paq_pkg::NOTIFY_ADDED;
               end
            end
         end
         paq_pkg::FUNC_NEXT: begin
            if (fill_ff != '0) begin
               finish_cmd     = paq_pkg::CELL_POP;
               entry_valid_in = 1'b1;
               out_entry_in   = entry_w[0];
               fill_in        = fill_ff - 1'b1;
               if (fill_ff != CW'(1)) begin
                  notify_in = paq_pkg::NOTIFY_CHANGED;
               end
            end
         end
         paq_pkg::FUNC_PEEK: begin
            if (fill_ff != '0) begin
               entry_valid_in = 1'b1;
               out_entry_in   = entry_w[0];
            end
         end
         paq_pkg::FUNC_COUNT: begin
         end
         paq_pkg::FUNC_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            status_in = paq_pkg::STATUS_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      ctrl.item   = item_ff;
      ctrl.normal = normal_ff;
      ctrl.cmd    = paq_pkg::CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ctrl.cmd = paq_pkg::CELL_SCAN_CLR;
            end
         end
         ST_SCAN: begin
            ctrl.cmd = paq_pkg::CELL_SCAN;
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.cmd = finish_cmd;
            end
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      paq_pkg::entry_type left_entry;
      paq_pkg::entry_type right_entry;
      logic               left_chain;

      if (i == 0) begin : g_head
         assign left_entry = item_ff;
         assign left_chain = 1'b0;
      end else begin : g_body
         assign left_entry = entry_w[i-1];
         assign left_chain = chain_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
      end

      paq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .occupied    (CW'(i) < fill_ff),
         .at_tail     (CW'(i) == fill_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_chain  (left_chain),
         .entry_out   (entry_w[i]),
         .chain_out   (chain_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         normal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_NORMAL_PRIORITY)) begin
            normal_ff <= csr_pwdata[7:0];
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  op_ff   <= req_tuser;
                  item_ff <= req_item;
                  cnt_ff  <= '0;
                  if ((req_tuser == paq_pkg::FUNC_POST) && !full) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_SCAN: begin
               if (cnt_ff == SCAN_LAST) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  fill_ff        <= fill_in;
                  rsp_valid_ff   <= 1'b1;
                  status_ff      <= status_in;
                  entry_valid_ff <= entry_valid_in;
                  out_entry_ff   <= out_entry_in;
                  occupancy_ff   <= paq_pkg::OCC_W'(fill_in);
                  notify_ff      <= notify_in;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, notify_ff, occupancy_ff, out_entry_ff.stamp,
                        out_entry_ff.prio, out_entry_ff.code, entry_valid_ff,
                        status_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("queue occupancy beyond its depth");

   a_scan_holds_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> $stable(fill_ff))
      else $error("occupancy changed during an insert scan");

   a_added_one_deep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (notify_ff == paq_pkg::NOTIFY_ADDED)) |->
         (occupancy_ff == paq_pkg::OCC_W'(1)))
      else $error("head added event without a one-deep queue");

   a_entry_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && entry_valid_ff) |-> (status_ff == paq_pkg::STATUS_OK))
      else $error("entry returned with an error status");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority alert queue unit. A clocked driver
// offers requests from a backlog in random bursts. It predicts each accepted
// request's response from its own copy of the queue. A clocked monitor
// stalls the response stream on its own pattern and checks each response,
// field by field, against the oldest prediction. The normal priority is
// reprogrammed between traffic phases while the queue is quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int PHASE_REQUESTS = 390;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
   localparam int MAX_REPORTS = 40;

   localparam logic [paq_pkg::FUNC_W-1:0] FUNC_UNKNOWN_FIRST = 3'd5;
   localparam logic [paq_pkg::FUNC_W-1:0] FUNC_UNKNOWN_MID   = 3'd6;
   localparam logic [paq_pkg::FUNC_W-1:0] FUNC_UNKNOWN_LAST  = 3'd7;
   localparam logic [2:0]                 NORMAL_PRIORITY_ADDR = 3'd0;

   typedef struct packed {
      logic [paq_pkg::FUNC_W-1:0]  func;
      logic [paq_pkg::CODE_W-1:0]  code;
      logic [paq_pkg::PRIO_W-1:0]  prio;
      logic [paq_pkg::STAMP_W-1:0] stamp;
   } alert_request_type;

   // Packed from the top bit down, so status sits in the lowest bits.
   typedef struct packed {
      logic [5:0]                   padding;
      logic [paq_pkg::NOTIFY_W-1:0] notify;
      logic [paq_pkg::OCC_W-1:0]    occupancy;
      logic [paq_pkg::STAMP_W-1:0]  stamp;
      logic [paq_pkg::PRIO_W-1:0]   prio;
      logic [paq_pkg::CODE_W-1:0]   code;
      logic                         entry_valid;
      logic [paq_pkg::STATUS_W-1:0] status;
   } alert_response_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [71:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [87:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   // Predicted queue contents and configuration.
   paq_pkg::entry_type          held_alerts [QUEUE_DEPTH];
   int unsigned                 held_count = 0;
   logic [paq_pkg::PRIO_W-1:0]  normal_level = '0;

   alert_request_type  alert_backlog [$];
   alert_response_type awaited_responses [$];
   alert_request_type  offered_request;
   int                 error_count = 0;

   int                 burst_left = 1;
   int                 gap_left = 0;
   ready_pattern_type  ready_pattern = READY_ALWAYS;
   int                 pattern_left = 0;
   int unsigned        ready_tick = 0;

   priority_alert_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("%0t: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   function automatic alert_response_type predict_alert_response(
      input alert_request_type r);
      alert_response_type rsp;
      int                 pos;
      int                 i;
      rsp = '0;
      rsp.status = paq_pkg::STATUS_OK;
      rsp.notify = paq_pkg::NOTIFY_NONE;
      case (r.func)
         paq_pkg::FUNC_POST: begin
            if (held_count >= QUEUE_DEPTH) begin
               rsp.status = paq_pkg::STATUS_FULL;
            end else begin
               // Normal priority always goes to the tail; anything else goes
               // ahead of the first entry of strictly lower priority.
               pos = held_count;
               if (r.prio != normal_level) begin
                  i = 0;
                  while (i < pos && held_alerts[i].prio >= r.prio)
                     i++;
                  pos = i;
               end
               for (i = held_count; i > pos; i--)
                  held_alerts[i] = held_alerts[i-1];
               held_alerts[pos] = '{code: r.code, prio: r.prio, stamp: r.stamp};
               held_count++;
               if (held_count == 1)
                  rsp.notify = paq_pkg::NOTIFY_ADDED;
            end
         end
         paq_pkg::FUNC_NEXT: begin
            if (held_count > 0) begin
               rsp.entry_valid = 1'b1;
               rsp.code = held_alerts[0].code;
               rsp.prio = held_alerts[0].prio;
               rsp.stamp = held_alerts[0].stamp;
               for (i = 1; i < held_count; i++)
                  held_alerts[i-1] = held_alerts[i];
               held_count--;
               if (held_count > 0)
                  rsp.notify = paq_pkg::NOTIFY_CHANGED;
            end
         end
         paq_pkg::FUNC_PEEK: begin
            if (held_count > 0) begin
               rsp.entry_valid = 1'b1;
               rsp.code = held_alerts[0].code;
               rsp.prio = held_alerts[0].prio;
               rsp.stamp = held_alerts[0].stamp;
            end
         end
         paq_pkg::FUNC_COUNT: begin
         end
         paq_pkg::FUNC_CLEAR: begin
            held_count = 0;
         end
         default: begin
            rsp.status = paq_pkg::STATUS_UNKNOWN;
         end
      endcase
      rsp.occupancy = held_count[paq_pkg::OCC_W-1:0];
      return rsp;
   endfunction

   function automatic logic [paq_pkg::PRIO_W-1:0] pick_priority(
      input logic [paq_pkg::PRIO_W-1:0] level);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         return level;
      else if (roll < 45)
         return level + 8'd1;
      else if (roll < 55)
         return level - 8'd1;
      else if (roll < 65)
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      else if (roll < 80)
         return 8'($urandom_range(0, 3));
      else
         return 8'($urandom_range(0, 255));
   endfunction

   function automatic alert_request_type make_request(
      input traffic_mix_type mix, input logic [paq_pkg::PRIO_W-1:0] level);
      alert_request_type r;
      int roll;
      int post_pct;
      int next_pct;
      r.code = $urandom();
      r.stamp = $urandom();
      r.prio = pick_priority(level);
      case (mix)
         MIX_FILL: begin
            post_pct = 70;
            next_pct = 12;
         end
         MIX_DRAIN: begin
            post_pct = 20;
            next_pct = 60;
         end
         default: begin
            post_pct = 42;
            next_pct = 35;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < post_pct)
         r.func = paq_pkg::FUNC_POST;
      else if (roll < post_pct + next_pct)
         r.func = paq_pkg::FUNC_NEXT;
      else if (roll < 95)
         r.func = ($urandom_range(0, 1) != 0) ? paq_pkg::FUNC_PEEK : paq_pkg::FUNC_COUNT;
      else if (roll < 96)
         r.func = paq_pkg::FUNC_CLEAR;
      else
         r.func = 3'($urandom_range(FUNC_UNKNOWN_FIRST, FUNC_UNKNOWN_LAST));
      return r;
   endfunction

   function automatic void queue_request(input logic [paq_pkg::FUNC_W-1:0] func,
                                         input logic [paq_pkg::CODE_W-1:0] code,
                                         input logic [paq_pkg::PRIO_W-1:0] prio,
                                         input logic [paq_pkg::STAMP_W-1:0] stamp);
      alert_backlog.push_back('{func: func, code: code, prio: prio, stamp: stamp});
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return 0;
      else if (roll < 8)
         return $urandom_range(1, 4);
      else
         return $urandom_range(5, 24);
   endfunction

   // Request driver: offers the backlog in bursts and predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_responses.push_back(predict_alert_response(offered_request));
         if (!req_tvalid || req_tready) begin
            if (gap_left == 0 && alert_backlog.size() > 0) begin
               offered_request = alert_backlog.pop_front();
               req_tdata <= {offered_request.stamp, offered_request.prio,
                             offered_request.code};
               req_tuser <= offered_request.func;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = pick_gap();
               end
            end else begin
               req_tvalid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end
         end
      end
   end

   // Response monitor with its own stall pattern.
   always @(posedge clock) begin
      alert_response_type seen;
      alert_response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (awaited_responses.size() == 0) begin
               report_mismatch("response with no request waiting");
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", seen.status, want.status);
               check_field("entry_valid", seen.entry_valid, want.entry_valid);
               check_field("out_code", seen.code, want.code);
               check_field("out_priority", seen.prio, want.prio);
               check_field("out_stamp", seen.stamp, want.stamp);
               check_field("occupancy", seen.occupancy, want.occupancy);
               check_field("notify", seen.notify, want.notify);
               check_field("padding", seen.padding, want.padding);
            end
         end
         if (pattern_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 300);
         end
         pattern_left--;
         ready_tick++;
         case (ready_pattern)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_COIN:     rsp_tready <= ($urandom_range(0, 1) != 0);
            READY_SPARSE:   rsp_tready <= ($urandom_range(0, 5) == 0);
            default:        rsp_tready <= (ready_tick % 5) < 2;
         endcase
      end
   end

   task automatic wait_until_quiet();
      @(negedge clock);
      while (alert_backlog.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_normal_priority(input logic [paq_pkg::PRIO_W-1:0] level);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= NORMAL_PRIORITY_ADDR;
      csr_pwdata <= {24'b0, level};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      normal_level = level;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      check_field("normal_priority readback", csr_prdata, {24'b0, level});
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [paq_pkg::PRIO_W-1:0] level);
      traffic_mix_type mix;
      int segment;
      int made;
      write_normal_priority(level);
      @(negedge clock);
      made = 0;
      while (made < PHASE_REQUESTS) begin
         mix = traffic_mix_type'($urandom_range(0, 2));
         segment = $urandom_range(5, 60);
         repeat (segment) begin
            alert_backlog.push_back(make_request(mix, level));
            made++;
         end
      end
      wait_until_quiet();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty queue, unknown operations, ordering ties and the head events,
      // with the normal priority still at its reset value of zero.
      queue_request(paq_pkg::FUNC_PEEK, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_NEXT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_request(paq_pkg::FUNC_COUNT, 32'h0, 8'h0, 32'h0);
      queue_request(FUNC_UNKNOWN_FIRST, 32'h1234_5678, 8'h11, 32'h9ABC_DEF0);
      queue_request(FUNC_UNKNOWN_MID, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_request(FUNC_UNKNOWN_LAST, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_POST, 32'hA000_0001, 8'h00, 32'h0000_0001);
      queue_request(paq_pkg::FUNC_POST, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_request(paq_pkg::FUNC_POST, 32'hA000_0003, 8'hFF, 32'h0000_0003);
      queue_request(paq_pkg::FUNC_POST, 32'h0000_0000, 8'h01, 32'h0000_0000);
      queue_request(paq_pkg::FUNC_POST, 32'hA000_0005, 8'h00, 32'h0000_0005);
      queue_request(paq_pkg::FUNC_POST, 32'hA000_0006, 8'h80, 32'h5555_AAAA);
      queue_request(paq_pkg::FUNC_PEEK, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_COUNT, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_NEXT, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_NEXT, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_CLEAR, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_NEXT, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_POST, 32'hAAAA_5555, 8'h7F, 32'h0F0F_F0F0);
      queue_request(paq_pkg::FUNC_NEXT, 32'h0, 8'h0, 32'h0);
      queue_request(paq_pkg::FUNC_PEEK, 32'h0, 8'h0, 32'h0);
      wait_until_quiet();

      run_random_phase(8'hFF);
      run_random_phase(8'h00);
      run_random_phase(8'($urandom_range(1, 254)));
      run_random_phase(8'h80);
      run_random_phase(8'($urandom_range(0, 255)));

      if (awaited_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   awaited_responses.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
design/paq_pkg.sv
design/paq_cell.sv
design/priority_alert_queue_unit.sv
sim/testbench.sv
